/* design/mpct_pkg.sv */
// shared types, constants and helpers for the mouse packet cursor tracker
// no dependencies
package mpct_pkg;

    localparam int CoordBits = 12;
    localparam int OutBits   = 12;
    localparam int LimitBits = 13;
    localparam int MotBits   = 7;
    localparam int SumBits   = CoordBits + 2;
    localparam int CmpBits   = (SumBits > LimitBits) ? SumBits : LimitBits;

    localparam int CoordMaxInt = (1 << CoordBits) - 1;
    localparam int HomeXInt    = 1024 / 2;
    localparam int HomeYInt    = 768 / 2;

    localparam logic [CoordBits-1:0] HomeX =
        (HomeXInt > CoordMaxInt) ? CoordBits'(CoordMaxInt) : CoordBits'(HomeXInt);
    localparam logic [CoordBits-1:0] HomeY =
        (HomeYInt > CoordMaxInt) ? CoordBits'(CoordMaxInt) : CoordBits'(HomeYInt);

    localparam logic [LimitBits-1:0] ResetWidth  = 13'd1024;
    localparam logic [LimitBits-1:0] ResetHeight = 13'd768;

    // configuration register indexes
    localparam logic RegScreenWidth  = 1'b0;
    localparam logic RegScreenHeight = 1'b1;

    typedef logic signed [MotBits-1:0] motion_t;

    typedef struct packed {
        logic [7:0] status;
        motion_t    dx;
        motion_t    dy;
    } pkt_t;

    // signed byte divided by 3, truncated toward zero
    function automatic motion_t div3_motion(input logic [7:0] b);
        logic [7:0]  mag;
        logic [15:0] prod;
        logic [6:0]  q;
        mag  = b[7] ? (~b + 8'd1) : b;
        // x*171 >> 9 equals x/3 for any 8-bit x
        prod = 16'(mag) * 16'd171;
        q    = prod[15:9];
        return b[7] ? motion_t'(-$signed(q)) : motion_t'(q);
    endfunction

endpackage

/* design/mpct_front.sv */
// byte framing: groups bytes into packets and scales the motion bytes
// depends on mpct_pkg
module mpct_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    data_byte,
    output logic          push,
    output mpct_pkg::pkt_t push_pkt,
    input  logic          q_full
);
    import mpct_pkg::*;

    typedef enum logic [2:0] {
        PH_STATUS = 3'b001,
        PH_DX     = 3'b010,
        PH_DY     = 3'b100
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] status_reg;
    motion_t    dx_reg;
    logic       take;

    // only the closing byte of a packet needs room in the queue
    assign in_ready = (phase_reg != PH_DY) || !q_full;
    assign take     = in_valid && in_ready;
    assign push     = take && (phase_reg == PH_DY);

    assign push_pkt.status = status_reg;
    assign push_pkt.dx     = dx_reg;
    assign push_pkt.dy     = div3_motion(data_byte);

    always_comb
    begin
        case (phase_reg)
            PH_STATUS: phase_next = PH_DX;
            PH_DX:     phase_next = PH_DY;
            PH_DY:     phase_next = PH_STATUS;
            default:   phase_next = PH_DX;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_STATUS;
            status_reg <= '0;
            dx_reg     <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            if (phase_reg == PH_DX)
            begin
                dx_reg <= div3_motion(data_byte);
            end
            else if (phase_reg != PH_DY)
            begin
                status_reg <= data_byte;
            end
        end
    end

endmodule

/* design/mpct_queue.sv */
// two-entry packet queue between the framing and the cursor update
// depends on mpct_pkg
module mpct_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mpct_pkg::pkt_t push_pkt,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output mpct_pkg::pkt_t head_pkt
);
    import mpct_pkg::*;

    pkt_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign head_pkt = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_pkt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

endmodule

/* design/mpct_back.sv */
// cursor update: applies packet motion within the screen limits, holds the result
// depends on mpct_pkg
module mpct_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [mpct_pkg::LimitBits-1:0] cfg_data,
    input  logic                           q_valid,
    input  mpct_pkg::pkt_t                 head_pkt,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     status_byte,
    output logic [mpct_pkg::OutBits-1:0]   cursor_x,
    output logic [mpct_pkg::OutBits-1:0]   cursor_y
);
    import mpct_pkg::*;

    logic [LimitBits-1:0] width_reg;
    logic [LimitBits-1:0] height_reg;
    logic [CoordBits-1:0] pos_x_reg, pos_x_next;
    logic [CoordBits-1:0] pos_y_reg, pos_y_next;
    logic                 out_valid_reg;
    logic [7:0]           status_reg;

    logic signed [SumBits-1:0] sum_x;
    logic signed [SumBits-1:0] sum_y;
    logic [CoordBits+OutBits-1:0] wide_x;
    logic [CoordBits+OutBits-1:0] wide_y;

    // new value kept only if strictly inside (0, limit) and representable
    function automatic logic in_range(input logic signed [SumBits-1:0] v,
                                      input logic [LimitBits-1:0] limit);
        logic ok;
        ok = !v[SumBits-1] && (v != '0)
             && (CmpBits'(unsigned'(v)) < CmpBits'(limit))
             && (v[SumBits-1:CoordBits] == '0);
        return ok;
    endfunction

    assign pop = q_valid && (!out_valid_reg || out_ready);

    assign sum_x = $signed({2'b00, pos_x_reg}) + SumBits'(head_pkt.dx);
    assign sum_y = $signed({2'b00, pos_y_reg}) - SumBits'(head_pkt.dy);

    assign pos_x_next = in_range(sum_x, width_reg)  ? sum_x[CoordBits-1:0] : pos_x_reg;
    assign pos_y_next = in_range(sum_y, height_reg) ? sum_y[CoordBits-1:0] : pos_y_reg;

    assign wide_x      = {{OutBits{1'b0}}, pos_x_reg};
    assign wide_y      = {{OutBits{1'b0}}, pos_y_reg};
    assign cursor_x    = wide_x[OutBits-1:0];
    assign cursor_y    = wide_y[OutBits-1:0];
    assign status_byte = status_reg;
    assign out_valid   = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ResetWidth;
            height_reg <= ResetHeight;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegScreenWidth:  width_reg  <= cfg_data;
                RegScreenHeight: height_reg <= cfg_data;
                default:         width_reg  <= width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg     <= HomeX;
            pos_y_reg     <= HomeY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                pos_x_reg     <= pos_x_next;
                pos_y_reg     <= pos_y_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= head_pkt.status;
        end
    end

endmodule

/* design/mouse_packet_cursor_tracker.sv */
// top level of the mouse packet cursor tracker
// depends on mpct_pkg, mpct_front, mpct_queue, mpct_back
//
// channel   handshake            payload
// input     in_valid/in_ready    data_byte
// output    out_valid/out_ready  status_byte, cursor_x, cursor_y
// config    cfg_we               cfg_index, cfg_data
//
// one byte per cycle is accepted while in_ready is high; the third byte of a
// packet goes into the queue as it is taken, and the packet at the queue head
// loads the output register when that register is empty or its result is taken
// input stalls only on the third byte of a packet while the queue holds two packets,
// which takes a stalled output register plus two more queued packets
// reset: phase at status byte, cursor at 512/384, limits 1024/768
module mouse_packet_cursor_tracker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     data_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     status_byte,
    output logic [mpct_pkg::OutBits-1:0]   cursor_x,
    output logic [mpct_pkg::OutBits-1:0]   cursor_y,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [mpct_pkg::LimitBits-1:0] cfg_data
);
    import mpct_pkg::*;

    logic push;
    pkt_t push_pkt;
    logic q_full;
    logic pop;
    logic q_valid;
    pkt_t head_pkt;

    mpct_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .push      (push),
        .push_pkt  (push_pkt),
        .q_full    (q_full)
    );

    mpct_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_pkt (push_pkt),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head_pkt (head_pkt)
    );

    mpct_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_valid     (q_valid),
        .head_pkt    (head_pkt),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status_byte (status_byte),
        .cursor_x    (cursor_x),
        .cursor_y    (cursor_y)
    );

endmodule
